[hw/rtl/sfdc_pkg.sv]
// sfdc_pkg: shared constants and codes for the stereo flanger / echo chain
// no dependencies; used by the top level, the sine unit and the checker
`timescale 1ns / 1ps

package sfdc_pkg;

   // default sizes of the two delay lines and of the lfo table
   localparam int FLANGER_ENTRIES_DEF = 4096;
   localparam int ECHO_ENTRIES_DEF    = 131072;
   localparam int SINE_ENTRIES_DEF    = 1024;

   // register map, one 32-bit word per register
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_FLANGER_DEPTH = 3'd0,
      REG_LFO_STEP      = 3'd1,
      REG_DELAY_TAPS    = 3'd2,
      REG_FEEDBACK_GAIN = 3'd3,
      REG_PREV_WEIGHT   = 3'd4
   } reg_index_type;

   localparam logic [15:0] FLANGER_DEPTH_RST = 16'd32768;
   localparam logic [15:0] LFO_STEP_RST      = 16'd0;
   localparam logic [16:0] DELAY_TAPS_RST    = 17'd24000;
   localparam logic [15:0] FEEDBACK_GAIN_RST = 16'd16384;
   localparam logic [15:0] PREV_WEIGHT_RST   = 16'd0;

endpackage

[hw/rtl/stereo_flanger_delay_chain.sv]
// stereo_flanger_delay_chain: top level, flanger line, echo line, smoothing, csr port
// depends on sfdc_pkg and sfdc_sine
`timescale 1ns / 1ps

// One stereo pair in, one pair out. An accepted request runs through a
// flanger (sine-lfo tap into a line of FLANGER_DEPTH_ENTRIES pairs, 0.7 dry
// plus 0.3 wet), a feedback echo (fixed tap into a line of ECHO_DEPTH_ENTRIES
// pairs, 0.75 dry plus 0.25 wet, line written with dry plus gain times wet)
// and a one-pair smoother weighted by the prev_weight register. A request
// goes from acceptance to the result register through the pipelined sine
// unit (the tap product is registered as its value comes out), a state for
// the tap addresses and the synchronous read of both lines, one for the
// flanger mix and its line write, one for the echo mix and its line write,
// and one for the smoothing step into the result register, which waits
// while an earlier result is still held by rsp_stall. One request is in
// flight at a time; the next is taken right after the result is loaded,
// even while rsp_valid waits on rsp_stall. Both lines come up reading as
// zero right after reset with no clearing pass: each line is written in
// address order, so a fill pointer plus a wrapped flag tells which entries
// hold data. Registers sit at byte addresses 0,4,8,12,16 and should be
// written only while the block is idle.

module stereo_flanger_delay_chain #(
   parameter int FLANGER_DEPTH_ENTRIES = sfdc_pkg::FLANGER_ENTRIES_DEF,
   parameter int ECHO_DEPTH_ENTRIES    = sfdc_pkg::ECHO_ENTRIES_DEF,
   parameter int SINE_ENTRIES          = sfdc_pkg::SINE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [15:0]              req_left_in,
   input  logic signed [15:0]              req_right_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [15:0]              rsp_left_out,
   output logic signed [15:0]              rsp_right_out,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sfdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import sfdc_pkg::*;

   localparam int FA  = $clog2(FLANGER_DEPTH_ENTRIES);
   localparam int EA  = $clog2(ECHO_DEPTH_ENTRIES);
   localparam int DW  = 33 + FA;
   localparam int ECW = (EA > 17) ? EA : 17;
   localparam logic [FA:0] FD_W = (FA + 1)'(FLANGER_DEPTH_ENTRIES);
   localparam logic [EA:0] ED_W = (EA + 1)'(ECHO_DEPTH_ENTRIES);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SINE = 6'b000010,
      ST_ADDR = 6'b000100,
      ST_MIX  = 6'b001000,
      ST_ECHO = 6'b010000,
      ST_HOLD = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [15:0]        flanger_depth_ff;
   logic [15:0]        lfo_step_ff;
   logic [16:0]        delay_taps_ff;
   logic signed [15:0] feedback_gain_ff;
   logic [15:0]        prev_weight_ff;

   // sequencing state
   logic [FA-1:0]      fl_idx_ff;
   logic               fl_full_ff;
   logic [15:0]        lfo_phase_ff;
   logic [EA-1:0]      ec_idx_ff;
   logic               ec_full_ff;
   logic signed [15:0] prior_l_ff, prior_r_ff;

   // per-request payload
   logic signed [15:0] dry_l_ff, dry_r_ff;
   logic [31:0]        amp_ff;
   logic               fl_hit_ff, ec_hit_ff;
   logic signed [15:0] mid1_l_ff, mid1_r_ff, mid2_l_ff, mid2_r_ff;
   logic signed [15:0] out_l_ff, out_r_ff;
   logic               rsp_valid_ff;

   // line memories, one pair per word: left low half, right high half
   logic [31:0] fl_mem [FLANGER_DEPTH_ENTRIES];
   logic [31:0] ec_mem [ECHO_DEPTH_ENTRIES];
   logic [31:0] fl_rdata_ff, ec_rdata_ff;

   logic               sine_start, sine_done;
   logic signed [15:0] sine_val;

   logic               accept, csr_wr, out_free;
   logic [DW-1:0]      d_full;
   logic [FA-1:0]      d_tap, fl_tap;
   logic [FA:0]        fl_rd_sum;
   logic [FA-1:0]      fl_rd;
   logic [ECW-1:0]     dt_ext;
   logic [EA-1:0]      ec_tap;
   logic [EA:0]        ec_rd_sum;
   logic [EA-1:0]      ec_rd;
   logic signed [15:0] wf_l, wf_r, we_l, we_r;
   logic signed [15:0] m1_l, m1_r, st_l, st_r, m2_l, m2_r, f_l, f_r;
   logic [16:0]        sine_bias;

   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      if (v > 36'sd32767) begin
         return 16'sh7fff;
      end else if (v < -36'sd32768) begin
         return -16'sh8000;
      end else begin
         return 16'(v);
      end
   endfunction

   // round to nearest, ties up, then saturate
   function automatic logic signed [15:0] rnd_sat(input logic signed [35:0] acc,
                                                  input logic [4:0] sh);
      logic signed [35:0] b;
      b = (acc + (36'sd1 <<< (sh - 5'd1))) >>> sh;
      return sat16(b);
   endfunction

   function automatic logic signed [15:0] mix_q15(input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic signed [35:0] wa,
                                                  input logic signed [35:0] wb);
      return rnd_sat(36'(a) * wa + 36'(b) * wb, 5'd15);
   endfunction

   function automatic logic signed [15:0] echo_store(input logic signed [15:0] mid,
                                                     input logic signed [15:0] wet,
                                                     input logic signed [15:0] gain);
      logic signed [35:0] fb;
      fb = (36'(wet) * 36'(gain) + 36'sd16384) >>> 15;
      return sat16(36'(mid) + fb);
   endfunction

   function automatic logic signed [15:0] smooth(input logic signed [15:0] cur,
                                                 input logic signed [15:0] prev,
                                                 input logic [15:0] m);
      logic signed [35:0] wm, wc;
      wm = 36'($signed({1'b0, m}));
      wc = 36'sd65536 - wm;
      return rnd_sat(36'(cur) * wc + 36'(prev) * wm, 5'd16);
   endfunction

   // handshakes
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign sine_start = accept;

   sfdc_sine #(
      .SINE_ENTRIES(SINE_ENTRIES)
   ) u_sine (
      .clock (clock),
      .reset (reset),
      .start (sine_start),
      .phase (lfo_phase_ff),
      .done  (sine_done),
      .sine  (sine_val)
   );

   // tap and read addresses
   always_comb begin
      sine_bias = 17'(17'sd32768 + 17'(sine_val));
      d_full = DW'(amp_ff) * DW'(FLANGER_DEPTH_ENTRIES);
      d_tap  = d_full[DW-1:33];
      fl_tap = ((FA + 1)'(d_tap) > FD_W - 1'b1) ? FA'(FD_W - 1'b1) : d_tap;
      fl_rd_sum = (fl_idx_ff >= fl_tap) ? (FA + 1)'(fl_idx_ff) - (FA + 1)'(fl_tap)
                                        : (FA + 1)'(fl_idx_ff) + FD_W - (FA + 1)'(fl_tap);
      fl_rd = fl_rd_sum[FA-1:0];

      dt_ext = ECW'(delay_taps_ff);
      ec_tap = (dt_ext > ECW'(ED_W - 1'b1)) ? EA'(ED_W - 1'b1) : dt_ext[EA-1:0];
      ec_rd_sum = (ec_idx_ff >= ec_tap) ? (EA + 1)'(ec_idx_ff) - (EA + 1)'(ec_tap)
                                        : (EA + 1)'(ec_idx_ff) + ED_W - (EA + 1)'(ec_tap);
      ec_rd = ec_rd_sum[EA-1:0];
   end

   // wet samples, zero where the line was never written
   always_comb begin
      wf_l = fl_hit_ff ? $signed(fl_rdata_ff[15:0])  : 16'sd0;
      wf_r = fl_hit_ff ? $signed(fl_rdata_ff[31:16]) : 16'sd0;
      we_l = ec_hit_ff ? $signed(ec_rdata_ff[15:0])  : 16'sd0;
      we_r = ec_hit_ff ? $signed(ec_rdata_ff[31:16]) : 16'sd0;
      m1_l = mix_q15(dry_l_ff, wf_l, 36'sd22938, 36'sd9830);
      m1_r = mix_q15(dry_r_ff, wf_r, 36'sd22938, 36'sd9830);
      st_l = echo_store(mid1_l_ff, we_l, feedback_gain_ff);
      st_r = echo_store(mid1_r_ff, we_r, feedback_gain_ff);
      m2_l = mix_q15(mid1_l_ff, we_l, 36'sd24576, 36'sd8192);
      m2_r = mix_q15(mid1_r_ff, we_r, 36'sd24576, 36'sd8192);
      f_l  = smooth(mid2_l_ff, prior_l_ff, prev_weight_ff);
      f_r  = smooth(mid2_r_ff, prior_r_ff, prev_weight_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            if (sine_done) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_MIX;
         ST_MIX:  state_in = ST_ECHO;
         ST_ECHO: state_in = ST_HOLD;
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         flanger_depth_ff <= FLANGER_DEPTH_RST;
         lfo_step_ff      <= LFO_STEP_RST;
         delay_taps_ff    <= DELAY_TAPS_RST;
         feedback_gain_ff <= FEEDBACK_GAIN_RST;
         prev_weight_ff   <= PREV_WEIGHT_RST;
         fl_idx_ff        <= '0;
         fl_full_ff       <= 1'b0;
         lfo_phase_ff     <= '0;
         ec_idx_ff        <= '0;
         ec_full_ff       <= 1'b0;
         prior_l_ff       <= '0;
         prior_r_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_FLANGER_DEPTH: flanger_depth_ff <= csr_pwdata[15:0];
               REG_LFO_STEP:      lfo_step_ff      <= csr_pwdata[15:0];
               REG_DELAY_TAPS:    delay_taps_ff    <= csr_pwdata[16:0];
               REG_FEEDBACK_GAIN: feedback_gain_ff <= $signed(csr_pwdata[15:0]);
               REG_PREV_WEIGHT:   prev_weight_ff   <= csr_pwdata[15:0];
               default: ;
            endcase
         end

         // flanger line advance, lfo restarts when the line wraps
         if (state_ff == ST_MIX) begin
            if ((FA + 1)'(fl_idx_ff) == FD_W - 1'b1) begin
               fl_idx_ff    <= '0;
               fl_full_ff   <= 1'b1;
               lfo_phase_ff <= '0;
            end else begin
               fl_idx_ff    <= fl_idx_ff + 1'b1;
               lfo_phase_ff <= lfo_phase_ff + lfo_step_ff;
            end
         end

         if (state_ff == ST_ECHO) begin
            if ((EA + 1)'(ec_idx_ff) == ED_W - 1'b1) begin
               ec_idx_ff  <= '0;
               ec_full_ff <= 1'b1;
            end else begin
               ec_idx_ff <= ec_idx_ff + 1'b1;
            end
         end

         // result register parts the pipeline from the consumer
         if (state_ff == ST_HOLD && out_free) begin
            rsp_valid_ff <= 1'b1;
            prior_l_ff   <= mid2_l_ff;
            prior_r_ff   <= mid2_r_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         dry_l_ff <= req_left_in;
         dry_r_ff <= req_right_in;
      end
      if (state_ff == ST_SINE) begin
         amp_ff <= 32'(sine_bias[15:0]) * 32'(flanger_depth_ff);
      end
      if (state_ff == ST_ADDR) begin
         fl_hit_ff <= fl_full_ff || (fl_rd < fl_idx_ff);
         ec_hit_ff <= ec_full_ff || (ec_rd < ec_idx_ff);
      end
      if (state_ff == ST_MIX) begin
         mid1_l_ff <= m1_l;
         mid1_r_ff <= m1_r;
      end
      if (state_ff == ST_ECHO) begin
         mid2_l_ff <= m2_l;
         mid2_r_ff <= m2_r;
      end
      // smoothing lands only once the previous result has left
      if (state_ff == ST_HOLD && out_free) begin
         out_l_ff <= f_l;
         out_r_ff <= f_r;
      end
   end

   // flanger line: read at the tap, then write the dry pair
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         fl_rdata_ff <= fl_mem[fl_rd];
      end
      if (state_ff == ST_MIX) begin
         fl_mem[fl_idx_ff] <= {dry_r_ff, dry_l_ff};
      end
   end

   // echo line: read at the tap, then write dry plus feedback
   always_ff @(posedge clock) begin
      if (state_ff == ST_ADDR) begin
         ec_rdata_ff <= ec_mem[ec_rd];
      end
      if (state_ff == ST_ECHO) begin
         ec_mem[ec_idx_ff] <= {st_r, st_l};
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      unique case (reg_index_type'(csr_paddr[4:2]))
         REG_FLANGER_DEPTH: csr_prdata = 32'(flanger_depth_ff);
         REG_LFO_STEP:      csr_prdata = 32'(lfo_step_ff);
         REG_DELAY_TAPS:    csr_prdata = 32'(delay_taps_ff);
         REG_FEEDBACK_GAIN: csr_prdata = 32'($unsigned(feedback_gain_ff));
         REG_PREV_WEIGHT:   csr_prdata = 32'(prev_weight_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;

endmodule

[hw/rtl/sfdc_sine.sv]
// sfdc_sine: seven-stage pipelined sine of the lfo phase (q14 polynomial)
// depends on sfdc_pkg for nothing but the table size default
`timescale 1ns / 1ps

module sfdc_sine #(
   parameter int SINE_ENTRIES = sfdc_pkg::SINE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        phase,
   output logic               done,
   output logic signed [15:0] sine
);
   import sfdc_pkg::*;

   localparam int KW = $clog2(SINE_ENTRIES);
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SINE_ENTRIES);
   localparam logic [KW:0] SE_W  = (KW + 1)'(SINE_ENTRIES);

   logic [6:0] vld_ff, vld_in;

   logic [KW-1:0] k_ff, k_in, k1_ff;
   logic [16:0]   qe_ff, qe_in;
   logic [1:0]    quad2_ff, quad3_ff, quad4_ff, quad5_ff;
   logic [14:0]   u2_in_u_ff, u3_ff, u4_ff, u5_ff;
   logic [14:0]   sq_ff, sq4_ff;
   logic [13:0]   inner_ff;
   logic [14:0]   midv_ff;
   logic signed [15:0] sine_ff;

   logic [15+KW+1:0]  ph_prod;
   logic [KW+33:0]    qe_prod;
   logic [KW+16:0]    num;
   logic [KW+17:0]    rem;
   logic [15:0]       q;
   logic [13:0]       frac;
   logic [14:0]       u_c;
   logic [29:0]       usq;
   logic [25:0]       sq_c;
   logic [28:0]       isq;
   logic [29:0]       rprod;
   logic [15:0]       r2;
   logic [14:0]       s_mag;

   assign vld_in = {vld_ff[5:0], start};

   always_comb begin
      ph_prod = (16 + KW + 1)'(phase) * (16 + KW + 1)'(SINE_ENTRIES);
      k_in    = ph_prod[16 +: KW];
      qe_prod = (KW + 34)'(k_ff) * (KW + 34)'(RECIP);
      qe_in   = qe_prod[32:16];
      // reciprocal estimate is low by at most one
      num  = {1'b0, k1_ff, 16'd0};
      rem  = (KW + 18)'(num) - (KW + 18)'(qe_ff) * (KW + 18)'(SE_W);
      q    = (rem >= (KW + 18)'(SE_W)) ? 16'(qe_ff + 17'd1) : qe_ff[15:0];
      frac = q[13:0];
      u_c  = q[14] ? (15'd16384 - {1'b0, frac}) : {1'b0, frac};
      usq  = u2_in_u_ff * u2_in_u_ff;
      sq_c = 26'(sq_ff) * 26'd1231;
      isq  = 29'(sq4_ff) * 29'(inner_ff);
      rprod = 30'(u5_ff) * 30'(midv_ff);
      r2    = {rprod[28:14], 1'b0};
      s_mag = (r2 > 16'd32767) ? 15'h7fff : r2[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      k_ff       <= k_in;
      k1_ff      <= k_ff;
      qe_ff      <= qe_in;
      quad2_ff   <= q[15:14];
      u2_in_u_ff <= u_c;
      quad3_ff   <= quad2_ff;
      u3_ff      <= u2_in_u_ff;
      sq_ff      <= usq[28:14];
      quad4_ff   <= quad3_ff;
      u4_ff      <= u3_ff;
      sq4_ff     <= sq_ff;
      inner_ff   <= 14'(14'd10583 - 14'(sq_c[25:14]));
      quad5_ff   <= quad4_ff;
      u5_ff      <= u4_ff;
      midv_ff    <= 15'(15'd25736 - 15'(isq[28:14]));
      sine_ff    <= quad5_ff[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
   end

   assign done = vld_ff[6];
   assign sine = sine_ff;

endmodule

[hw/rtl/sfdc_checker.sv]
// sfdc_checker: port-level assertions for stereo_flanger_delay_chain, bound to the top
// depends on sfdc_pkg and the top-level port list
`timescale 1ns / 1ps

module sfdc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [15:0]              rsp_left_out,
   input logic signed [15:0]              rsp_right_out,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [sfdc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]                     csr_pwdata,
   input logic [31:0]                     csr_prdata
);
   import sfdc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_out)
                                 && $stable(rsp_right_out))
      else $error("stalled result changed");

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // a result never appears the cycle after an accept from an empty output
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   // a smoothing weight write reads back
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr[4:2] == REG_PREV_WEIGHT
       ##1 csr_paddr[4:2] == REG_PREV_WEIGHT)
      |-> csr_prdata == {16'd0, $past(csr_pwdata[15:0])})
      else $error("register readback mismatch");

endmodule

bind stereo_flanger_delay_chain sfdc_checker u_sfdc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_left_out  (rsp_left_out),
   .rsp_right_out (rsp_right_out),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);

[sim/tb_top.sv]
// tb_top: self-checking bench for stereo_flanger_delay_chain, a queue-fed driver,
// a clocked monitor and a bit-true predictor of the flanger, echo and smoothing chain
// depends on sfdc_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;
   import sfdc_pkg::*;

   localparam int FL_N   = FLANGER_ENTRIES_DEF;
   localparam int EC_N   = ECHO_ENTRIES_DEF;
   localparam int SIN_N  = SINE_ENTRIES_DEF;
   localparam int SETTLE = 20;
   localparam int REG_UNMAPPED = 5;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [15:0] req_left_in, req_right_in, rsp_left_out, rsp_right_out;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   stereo_flanger_delay_chain dut (.*);

   // predictor state, mirrors the block after reset
   logic [31:0] fl_line [FL_N];
   logic [31:0] ec_line [EC_N];
   int unsigned fl_pos, ec_pos, lfo_phase;
   logic signed [15:0] prev_l, prev_r;
   logic [15:0] depth_q, step_q, mix_q;
   logic [16:0] echo_tap_q;
   logic signed [15:0] fb_gain_q;

   // requests waiting to be offered, and output pairs still owed by the block
   logic [31:0] pending_pairs[$];
   logic [31:0] owed_pairs[$];
   int send_idle, recv_idle;      // percent of cycles each side idles
   int errors = 0;
   int checked = 0;
   int sent = 0;
   int queued = 0;
   bit long_hold_done = 1'b0;
   int hold_left = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- arithmetic
   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // round to nearest, ties up, then saturate
   function automatic logic signed [15:0] round_sat(longint v, int n);
      return sat16((v + (longint'(1) <<< (n - 1))) >>> n);
   endfunction

   // quarter-wave polynomial sine in q15, phase in 1/65536 turns
   function automatic longint lfo_sine(int unsigned phase);
      longint k, q, quad, f, u, u2, inner, mid, r, s;
      k = (longint'(phase) * SIN_N) >> 16;
      q = (k * 65536) / SIN_N;
      quad = (q >> 14) & 3;
      f = q & 16383;
      u = quad[0] ? 16384 - f : f;
      u2 = (u * u) >> 14;
      inner = 10583 - ((u2 * 1231) >> 14);
      mid = 25736 - ((u2 * inner) >> 14);
      r = (u * mid) >> 14;
      s = (2 * r > 32767) ? 32767 : 2 * r;
      return quad[1] ? -s : s;
   endfunction

   // predictor state after reset
   function automatic void reset_model();
      foreach (fl_line[i]) fl_line[i] = '0;
      foreach (ec_line[i]) ec_line[i] = '0;
      fl_pos = 0;
      ec_pos = 0;
      lfo_phase = 0;
      prev_l = '0;
      prev_r = '0;
   endfunction

   // one request through the whole chain; queues the expected output pair
   function automatic void process_pair(logic signed [15:0] in_l, logic signed [15:0] in_r);
      logic signed [15:0] dry[2], wet[2], mid[2], fin[2];
      longint d, fbk;
      int unsigned tap, rd;
      logic [31:0] ent;
      dry[0] = in_l;
      dry[1] = in_r;
      // flanger, tap from the lfo, clamped inside the line
      d = ((32768 + lfo_sine(lfo_phase)) * longint'(depth_q) * FL_N) >> 33;
      tap = (d > FL_N - 1) ? FL_N - 1 : int'(d);
      rd = (fl_pos >= tap) ? fl_pos - tap : fl_pos + FL_N - tap;
      ent = fl_line[rd];
      wet[0] = ent[15:0];
      wet[1] = ent[31:16];
      for (int c = 0; c < 2; c++)
         mid[c] = round_sat(longint'(dry[c]) * 22938 + longint'(wet[c]) * 9830, 15);
      fl_line[fl_pos] = {dry[1], dry[0]};
      fl_pos++;
      if (fl_pos >= FL_N) begin
         fl_pos = 0;
         lfo_phase = 0;   // lfo restarts when the line wraps
      end else begin
         lfo_phase = (lfo_phase + step_q) & 16'hFFFF;
      end
      // echo with feedback
      tap = (echo_tap_q > EC_N - 1) ? EC_N - 1 : echo_tap_q;
      rd = (ec_pos >= tap) ? ec_pos - tap : ec_pos + EC_N - tap;
      ent = ec_line[rd];
      wet[0] = ent[15:0];
      wet[1] = ent[31:16];
      for (int c = 0; c < 2; c++) begin
         fbk = (longint'(wet[c]) * fb_gain_q + 16384) >>> 15;
         dry[c] = sat16(longint'(mid[c]) + fbk);
         mid[c] = round_sat(longint'(mid[c]) * 24576 + longint'(wet[c]) * 8192, 15);
      end
      ec_line[ec_pos] = {dry[1], dry[0]};
      ec_pos = (ec_pos + 1) % EC_N;
      // smoothing against the previous pair
      fin[0] = round_sat(longint'(mid[0]) * (65536 - longint'(mix_q))
                         + longint'(prev_l) * longint'(mix_q), 16);
      fin[1] = round_sat(longint'(mid[1]) * (65536 - longint'(mix_q))
                         + longint'(prev_r) * longint'(mix_q), 16);
      prev_l = mid[0];
      prev_r = mid[1];
      owed_pairs.push_back({fin[1], fin[0]});
   endfunction

   // ---------------------------------------------------------------- driver
   // a stalled request holds still; a new one is offered only when the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_left_in <= '0;
         req_right_in <= '0;
         reset_model();
      end else begin
         if (req_valid && !req_stall) begin
            process_pair(req_left_in, req_right_in);
            sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
               logic [31:0] nxt;
               nxt = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_left_in <= nxt[15:0];
               req_right_in <= nxt[31:16];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_pairs.size() == 0) begin
            $error("unexpected output pair %0d/%0d", rsp_left_out, rsp_right_out);
            errors++;
         end else begin
            logic [31:0] exp_pair;
            exp_pair = owed_pairs.pop_front();
            if (rsp_left_out !== exp_pair[15:0]) begin
               $error("left_out expected %0d actual %0d",
                      $signed(exp_pair[15:0]), rsp_left_out);
               errors++;
            end
            if (rsp_right_out !== exp_pair[31:16]) begin
               $error("right_out expected %0d actual %0d",
                      $signed(exp_pair[31:16]), rsp_right_out);
               errors++;
            end
         end
         checked++;
      end
   end

   // ---------------------------------------------------------------- receiver
   // one long hold-off mid run so the block backs up onto its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (checked >= 1200 && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // ---------------------------------------------------------------- csr access
   // setup cycle then access cycle; the register takes the value on the access edge
   task automatic csr_write(int idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_FLANGER_DEPTH: depth_q = value[15:0];
         REG_LFO_STEP:      step_q = value[15:0];
         REG_DELAY_TAPS:    echo_tap_q = value[16:0];
         REG_FEEDBACK_GAIN: fb_gain_q = value[15:0];
         REG_PREV_WEIGHT:   mix_q = value[15:0];
         default: ;         // unmapped index, block ignores it
      endcase
   endtask

   task automatic write_all(logic [31:0] dep, logic [31:0] stp, logic [31:0] tap,
                            logic [31:0] gain, logic [31:0] mix);
      csr_write(REG_FLANGER_DEPTH, dep);
      csr_write(REG_LFO_STEP, stp);
      csr_write(REG_DELAY_TAPS, tap);
      csr_write(REG_FEEDBACK_GAIN, gain);
      csr_write(REG_PREV_WEIGHT, mix);
   endtask

   // every queued request has come back out before registers are touched
   task automatic drain();
      wait (checked == queued);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic void queue_pair(logic [31:0] p);
      pending_pairs.push_back(p);
      queued++;
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         queue_pair({rand_sample(), rand_sample()});
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin
      logic [15:0] edge_vals[6];
      edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
      send_idle = 19; recv_idle = 75;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      depth_q = FLANGER_DEPTH_RST; step_q = LFO_STEP_RST; echo_tap_q = DELAY_TAPS_RST;
      fb_gain_q = FEEDBACK_GAIN_RST; mix_q = PREV_WEIGHT_RST;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: sample extremes under reset settings
      foreach (edge_vals[i]) queue_pair({edge_vals[5 - i], edge_vals[i]});
      drain();
      // zero taps on both lines, hard feedback, full smoothing, fast lfo
      write_all(32'd0, 32'hFFFF, 32'd0, 32'h8000, 32'hFFFF);
      csr_write(REG_UNMAPPED, 32'h1234);   // unmapped index is ignored
      for (int i = 0; i < 8; i++)
         queue_pair({edge_vals[i % 6], edge_vals[(i + 2) % 6]});
      drain();
      // saturation: full-scale input with strong positive feedback on a short echo
      write_all(32'hFFFF, 32'd1, 32'd1, 32'h7FFF, 32'd0);
      repeat (8) queue_pair({16'h7FFF, 16'h7FFF});
      repeat (4) queue_pair({16'h8000, 16'h8000});
      drain();

      // random, sender light / receiver heavy; short echo, max depth
      write_all(32'hFFFF_FFFF, 32'd700, 32'd5, 32'hC000, 32'h8000);
      queue_random(500);
      drain();
      // random, roles swapped; echo tap at the last entry of the line, the largest tap the register holds
      send_idle = 75; recv_idle = 19;
      write_all(32'd20000, 32'd13, 32'hFFFF_FFFF, 32'd32767, 32'd1);
      queue_random(500);
      drain();
      // random, no idling; long hold-off lands here
      send_idle = 0; recv_idle = 0;
      write_all(32'd45000, 32'd65535, 32'd37, 32'hFFFF_8000, 32'hFFFF);
      queue_random(520);
      drain();

      $display("tb_top: %0d requests sent, %0d pairs checked over six register settings",
               sent, checked);
      if (errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #10ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
